FILE: src/sci_pkg.sv
`timescale 1ns / 1ps

package sci_pkg;

    // parameter defaults
    localparam int PWM_MIN_DEF        = 6;
    localparam int PWM_MAX_DEF        = 44;
    localparam int ADC_FULL_SCALE_DEF = 1023;
    localparam int TEXT_DEPTH_DEF     = 16;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int JOINT_W  = 2;
    localparam int COUNTS_W = 8;
    localparam int SAMPLE_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_JOINTS = 4;

    // scaler datapath
    localparam int DEG_W       = 16;
    localparam int PROD_W      = COUNTS_W + DEG_W;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QUOT_W      = PROD_W + 1;
    localparam int WIDE_W      = PROD_W + RECIP_W;

    localparam int DEG_RANGE = 180;
    localparam int DEG_SAT   = 65535;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_REL   = 8'h72;
    localparam logic [CHAR_W-1:0] CHAR_CLAIM = 8'h63;

    // joint limit reset values
    localparam logic [COUNTS_W-1:0] JMIN_RST [NUM_JOINTS] = '{8'd6, 8'd7, 8'd9, 8'd6};
    localparam logic [COUNTS_W-1:0] JMAX_RST [NUM_JOINTS] = '{8'd44, 8'd26, 8'd30, 8'd15};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_SPAN,
        ST_MUL,
        ST_DONE
    } sci_state_t;

    typedef struct packed {
        logic start;
        logic adc_mode;
    } sci_scale_req_t;

endpackage

FILE: src/sci_if.sv
`timescale 1ns / 1ps

interface sci_cmd_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_char;
    logic [1:0] sample_channel;
    logic [9:0] sample_value;

    modport source (output valid, action, rx_char, sample_channel, sample_value,
                    input ready);
    modport sink (input valid, action, rx_char, sample_channel, sample_value,
                  output ready);
endinterface

interface sci_servo_if;
    logic       valid;
    logic       ready;
    logic       servo_write;
    logic [1:0] servo_joint;
    logic [7:0] servo_counts;
    logic       remote_claimed;

    modport source (output valid, servo_write, servo_joint, servo_counts, remote_claimed,
                    input ready);
    modport sink (input valid, servo_write, servo_joint, servo_counts, remote_claimed,
                  output ready);
endinterface

FILE: src/sci_scaler.sv
`timescale 1ns / 1ps

module sci_scaler #(
    parameter int ADC_FULL_SCALE = sci_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sci_pkg::sci_scale_req_t             req,
    input  logic [sci_pkg::COUNTS_W-1:0]        op_a,
    input  logic [sci_pkg::DEG_W-1:0]           op_b,
    output logic                                done,
    output logic [sci_pkg::QUOT_W-1:0]          quot
);
    import sci_pkg::*;

    // floor(p / d) as (p * ceil(2^32 / d)) >> 32, exact for the product ranges used
    localparam logic [RECIP_W-1:0] RECIP_DEG =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEG_RANGE) - 64'd1) / 64'(DEG_RANGE));
    localparam logic [RECIP_W-1:0] RECIP_ADC =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1)
                 / 64'(ADC_FULL_SCALE));

    logic              v1_reg;
    logic              v2_reg;
    logic              mode1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [WIDE_W-1:0] wide;

    assign wide = WIDE_W'(prod_reg) * WIDE_W'(mode1_reg ? RECIP_ADC : RECIP_DEG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg  <= PROD_W'(op_a) * PROD_W'(op_b);
            mode1_reg <= req.adc_mode;
        end
        if (v1_reg)
        begin
            quot_reg <= wide[WIDE_W-1:RECIP_SHIFT];
        end
    end

    assign done = v2_reg;
    assign quot = quot_reg;

endmodule

FILE: src/servo_command_interpreter.sv
`timescale 1ns / 1ps
// servo command interpreter
// cmd channel: one item per serial character (action 0) or adc sample (action 1).
// servo channel: exactly one result item per cmd item, in order; servo_write marks
// a new joint position, remote_claimed gives the control mode after that item.
// cfg port: cfg_we with cfg_index 0..7 writes joint min/max limits (even = min,
// odd = max); write only while no item is in flight.
// items are accepted only in the idle state. a plain character is stored in the
// text buffer; a carriage return checks the first stored character, and a joint
// command scans the stored digits and goes through the scaler, as does an adc
// sample; an adc sample ignored while claimed goes straight to the done state.
// the joint command scan uses the text buffer's single read port, which
// is walked one stored character per cycle; the scaling takes two multiply stages.
// the result then goes into an output register, so a new item is taken
// while a result still waits; if the receiver stalls, a further result holds the
// sequencer in its done state until the output register frees.
// reset clears the character count and the claim flag and loads the default joint
// limits; the text buffer itself is not cleared, only written entries are read.
module servo_command_interpreter #(
    parameter int PWM_MIN        = sci_pkg::PWM_MIN_DEF,
    parameter int PWM_MAX        = sci_pkg::PWM_MAX_DEF,
    parameter int ADC_FULL_SCALE = sci_pkg::ADC_FULL_SCALE_DEF,
    parameter int TEXT_DEPTH     = sci_pkg::TEXT_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sci_cmd_if.sink                           cmd,
    sci_servo_if.source                       servo,
    input  logic                              cfg_we,
    input  logic [sci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sci_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sci_pkg::*;

    localparam int IDX_W = $clog2(TEXT_DEPTH);
    localparam logic [COUNTS_W-1:0] DEG_SPAN =
        (PWM_MAX < PWM_MIN) ? '0 : COUNTS_W'(PWM_MAX - PWM_MIN);

    sci_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      count_reg, count_next;
    logic                  claimed_reg, claimed_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [DEG_W-1:0]      deg_reg, deg_next;
    logic [JOINT_W-1:0]    joint_reg, joint_next;
    logic                  adc_reg, adc_next;
    logic                  res_write_reg, res_write_next;
    logic [COUNTS_W-1:0]   res_counts_reg, res_counts_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_write_reg;
    logic [JOINT_W-1:0]    out_joint_reg;
    logic [COUNTS_W-1:0]   out_counts_reg;
    logic                  out_claimed_reg;

    logic [COUNTS_W-1:0]   jmin_reg [NUM_JOINTS];
    logic [COUNTS_W-1:0]   jmax_reg [NUM_JOINTS];

    logic [CHAR_W-1:0]     text_mem [TEXT_DEPTH];
    logic [CHAR_W-1:0]     text_rd_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr;

    logic                  cmd_fire;
    logic                  out_load;
    sci_scale_req_t        scale_req;
    logic [COUNTS_W-1:0]   scale_a;
    logic                  scale_done;
    logic [QUOT_W-1:0]     scale_quot;

    logic [COUNTS_W-1:0]   cur_min;
    logic [COUNTS_W-1:0]   cur_max;
    logic [COUNTS_W-1:0]   adc_span;
    logic [SAMPLE_W-1:0]   sample_sat;
    logic [CHAR_W-1:0]     digit_val;
    logic [CHAR_W-1:0]     joint_digit;
    logic [DEG_W+3:0]      deg_mac;
    logic [QUOT_W:0]       serial_v;
    logic                  first_is_joint;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || servo.ready);

    assign cur_min  = jmin_reg[joint_reg];
    assign cur_max  = jmax_reg[joint_reg];
    assign adc_span = (cur_max >= cur_min) ? (cur_max - cur_min) : '0;

    assign sample_sat = (cmd.sample_value > SAMPLE_W'(ADC_FULL_SCALE))
                        ? SAMPLE_W'(ADC_FULL_SCALE) : cmd.sample_value;

    assign digit_val   = text_rd_reg - CHAR_ZERO;
    assign joint_digit = text_rd_reg - CHAR_ZERO;
    assign deg_mac     = ((DEG_W+4)'(deg_reg) << 3) + ((DEG_W+4)'(deg_reg) << 1)
                         + (DEG_W+4)'(digit_val[3:0]);
    assign serial_v    = (QUOT_W+1)'(scale_quot) + (QUOT_W+1)'(PWM_MIN);

    assign first_is_joint = (count_reg != '0) && (text_rd_reg >= CHAR_ZERO)
                            && (text_rd_reg <= CHAR_THREE) && claimed_reg;

    assign scale_a = adc_reg ? adc_span : DEG_SPAN;

    sci_scaler #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_scaler (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req),
        .op_a  (scale_a),
        .op_b  (deg_reg),
        .done  (scale_done),
        .quot  (scale_quot)
    );

    // text buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[count_reg] <= cmd.rx_char;
        end
        text_rd_reg <= text_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        claimed_next    = claimed_reg;
        k_next          = k_reg;
        deg_next        = deg_reg;
        joint_next      = joint_reg;
        adc_next        = adc_reg;
        res_write_next  = res_write_reg;
        res_counts_next = res_counts_reg;
        mem_we          = 1'b0;
        rd_addr         = '0;
        scale_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    res_write_next  = 1'b0;
                    res_counts_next = '0;
                    joint_next      = '0;
                    if (!cmd.action)
                    begin
                        if (cmd.rx_char == CHAR_CR)
                        begin
                            state_next = ST_FIRST;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = (count_reg == IDX_W'(TEXT_DEPTH - 1))
                                         ? '0 : count_reg + IDX_W'(1);
                            state_next = ST_DONE;
                        end
                    end
                    else if (claimed_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        joint_next = cmd.sample_channel;
                        deg_next   = DEG_W'(sample_sat);
                        adc_next   = 1'b1;
                        state_next = ST_SPAN;
                    end
                end
            end
            ST_FIRST:
            begin
                if (first_is_joint)
                begin
                    joint_next = joint_digit[JOINT_W-1:0];
                    deg_next   = '0;
                    k_next     = IDX_W'(1);
                    adc_next   = 1'b0;
                    rd_addr    = IDX_W'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    if (count_reg == IDX_W'(1) && text_rd_reg == CHAR_REL)
                    begin
                        claimed_next = 1'b0;
                    end
                    else if (count_reg == IDX_W'(1) && text_rd_reg == CHAR_CLAIM)
                    begin
                        claimed_next = 1'b1;
                    end
                    count_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                // text_rd_reg holds entry k_reg
                if (k_reg < count_reg)
                begin
                    if (text_rd_reg >= CHAR_ZERO && text_rd_reg <= CHAR_NINE)
                    begin
                        deg_next = (deg_mac > (DEG_W+4)'(DEG_SAT))
                                   ? DEG_W'(DEG_SAT) : deg_mac[DEG_W-1:0];
                    end
                    k_next  = k_reg + IDX_W'(1);
                    rd_addr = k_reg + IDX_W'(1);
                end
                else
                begin
                    count_next = '0;
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                scale_req.start    = 1'b1;
                scale_req.adc_mode = adc_reg;
                state_next         = ST_MUL;
            end
            ST_MUL:
            begin
                if (scale_done)
                begin
                    res_write_next = 1'b1;
                    if (adc_reg)
                    begin
                        res_counts_next = scale_quot[COUNTS_W-1:0] + cur_min;
                    end
                    else if (serial_v > (QUOT_W+1)'(cur_max))
                    begin
                        res_counts_next = cur_max;
                    end
                    else if (serial_v < (QUOT_W+1)'(cur_min))
                    begin
                        res_counts_next = cur_min;
                    end
                    else
                    begin
                        res_counts_next = serial_v[COUNTS_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (servo.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            claimed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            claimed_reg   <= claimed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        deg_reg        <= deg_next;
        joint_reg      <= joint_next;
        adc_reg        <= adc_next;
        res_write_reg  <= res_write_next;
        res_counts_reg <= res_counts_next;
        if (out_load)
        begin
            out_write_reg   <= res_write_reg;
            out_joint_reg   <= joint_reg;
            out_counts_reg  <= res_counts_reg;
            out_claimed_reg <= claimed_reg;
        end
    end

    // joint limits, even index is min and odd index is max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                jmin_reg[i] <= JMIN_RST[i];
                jmax_reg[i] <= JMAX_RST[i];
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0])
            begin
                jmax_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
            end
            else
            begin
                jmin_reg[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
            end
        end
    end

    assign servo.valid          = out_valid_reg;
    assign servo.servo_write    = out_write_reg;
    assign servo.servo_joint    = out_joint_reg;
    assign servo.servo_counts   = out_counts_reg;
    assign servo.remote_claimed = out_claimed_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (k_reg <= count_reg))
        else $error("scan index ran past the character count");

    a_scale_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        scale_done |-> (state_reg == ST_MUL))
        else $error("scaler finished outside the multiply wait");

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start processing");

    a_adc_only_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_write_reg && adc_reg) |-> !claimed_reg)
        else $error("adc position issued while remote control is claimed");

endmodule

FILE: verif/tb_servo_command_interpreter.sv
`timescale 1ns / 1ps

module tb_servo_command_interpreter;
    import sci_pkg::*;

    localparam logic ACT_CHAR    = 1'b0;
    localparam logic ACT_SAMPLE  = 1'b1;
    localparam logic REG_SEL_MIN = 1'b0;
    localparam logic REG_SEL_MAX = 1'b1;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = TEXT_DEPTH_DEF + 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [63:0] PWM_LO    = 64'(PWM_MIN_DEF);
    localparam logic [63:0] PWM_HI    = 64'(PWM_MAX_DEF);
    localparam logic [63:0] DEG_SPAN  = (PWM_HI < PWM_LO) ? 64'd0 : PWM_HI - PWM_LO;
    localparam logic [63:0] DEG_DIV   = 64'(DEG_RANGE);
    localparam logic [63:0] DEG_LIMIT = 64'(DEG_SAT);
    localparam logic [63:0] ADC_TOP   = 64'(ADC_FULL_SCALE_DEF);

    typedef enum {
        LIM_DEFAULT,
        LIM_WIDE,
        LIM_ZERO,
        LIM_FULL,
        LIM_EQUAL,
        LIM_INVERTED,
        LIM_RANDOM
    } limit_mode_t;

    typedef struct packed {
        logic                action;
        logic [CHAR_W-1:0]   rx_char;
        logic [JOINT_W-1:0]  channel;
        logic [SAMPLE_W-1:0] sample;
    } cmd_item_t;

    typedef struct packed {
        logic                pos_write;
        logic [JOINT_W-1:0]  joint;
        logic [COUNTS_W-1:0] counts;
        logic                claimed;
    } servo_pos_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sci_cmd_if   cmd_ch ();
    sci_servo_if servo_ch ();

    servo_command_interpreter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .servo     (servo_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the interpreter state
    logic [CHAR_W-1:0]   text_mem [TEXT_DEPTH_DEF];
    int                  text_fill;
    bit                  remote_now;
    logic [COUNTS_W-1:0] lim_min [NUM_JOINTS];
    logic [COUNTS_W-1:0] lim_max [NUM_JOINTS];

    servo_pos_t pending_positions [$];
    int         fail_count;
    int         items_sent;
    int         cycle_count;
    bit         idle_on;
    bit         hold_req;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_servo_command_interpreter NOT OK");
            $finish;
        end
    end

    function automatic servo_pos_t interpret_item(input cmd_item_t it);
        servo_pos_t          r;
        logic [CHAR_W-1:0]   lead;
        logic [CHAR_W-1:0]   d;
        logic [63:0]         deg;
        logic [63:0]         pos;
        logic [63:0]         span;
        logic [63:0]         s;
        int                  j;
        int                  k;
        r = '0;
        if (it.action == ACT_CHAR)
        begin
            if (it.rx_char == CHAR_CR)
            begin
                lead = text_mem[0];
                if (text_fill > 0 && lead >= CHAR_ZERO && lead <= CHAR_THREE && remote_now)
                begin
                    deg = '0;
                    for (k = 1; k < text_fill; k++)
                    begin
                        d = text_mem[k];
                        if (d >= CHAR_ZERO && d <= CHAR_NINE)
                        begin
                            deg = deg * 10 + 64'(d - CHAR_ZERO);
                            if (deg > DEG_LIMIT)
                                deg = DEG_LIMIT;
                        end
                    end
                    j = int'(lead - CHAR_ZERO) & 3;
                    pos = DEG_SPAN * deg / DEG_DIV + PWM_LO;
                    // max is tested first, so an inverted pair yields max, or min when pos is not above max
                    if (pos > 64'(lim_max[j]))
                        pos = 64'(lim_max[j]);
                    else if (pos < 64'(lim_min[j]))
                        pos = 64'(lim_min[j]);
                    r.pos_write = 1'b1;
                    r.joint     = j[JOINT_W-1:0];
                    r.counts    = pos[COUNTS_W-1:0];
                end
                else if (text_fill == 1 && lead == CHAR_REL)
                    remote_now = 1'b0;
                else if (text_fill == 1 && lead == CHAR_CLAIM)
                    remote_now = 1'b1;
                text_fill = 0;
            end
            else
            begin
                text_mem[text_fill] = it.rx_char;
                text_fill = (text_fill + 1) % TEXT_DEPTH_DEF;
            end
        end
        else if (!remote_now)
        begin
            j = int'(it.channel);
            s = 64'(it.sample);
            if (s > ADC_TOP)
                s = ADC_TOP;
            span = (lim_max[j] >= lim_min[j]) ? 64'(lim_max[j] - lim_min[j]) : 64'd0;
            pos = span * s / ADC_TOP + 64'(lim_min[j]);
            r.pos_write = 1'b1;
            r.joint     = it.channel;
            r.counts    = pos[COUNTS_W-1:0];
        end
        r.claimed = remote_now;
        return r;
    endfunction

    // receiver side: random stalls plus an optional long hold-off
    initial
    begin : servo_sink
        int hold_left;
        int stall_left;
        bit hold_taken;
        hold_left  = 0;
        stall_left = 0;
        hold_taken = 1'b0;
        servo_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                servo_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                servo_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                servo_ch.ready <= 1'b0;
            end
            else
                servo_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_servo
        servo_pos_t want;
        servo_pos_t got;
        if (rst_n && servo_ch.valid && servo_ch.ready)
        begin
            got = '{servo_ch.servo_write, servo_ch.servo_joint,
                    servo_ch.servo_counts, servo_ch.remote_claimed};
            if (pending_positions.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected servo item: write=%0d joint=%0d counts=%0d claimed=%0d",
                             got.pos_write, got.joint, got.counts, got.claimed);
            end
            else
            begin
                want = pending_positions.pop_front();
                if (got.pos_write !== want.pos_write || got.joint !== want.joint ||
                    got.counts !== want.counts || got.claimed !== want.claimed)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("servo mismatch: expected write=%0d joint=%0d counts=%0d %s%0d",
                                 want.pos_write, want.joint, want.counts, "claimed=",
                                 want.claimed);
                        $display("                got write=%0d joint=%0d counts=%0d %s%0d",
                                 got.pos_write, got.joint, got.counts, "claimed=",
                                 got.claimed);
                    end
                end
            end
        end
    end

    // valid stays high between back-to-back items
    task automatic send_item(input cmd_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.action         <= it.action;
        cmd_ch.rx_char        <= it.rx_char;
        cmd_ch.sample_channel <= it.channel;
        cmd_ch.sample_value   <= it.sample;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_positions.push_back(interpret_item(it));
        items_sent++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        cmd_item_t it;
        it.action  = ACT_CHAR;
        it.rx_char = c;
        it.channel = JOINT_W'($urandom_range(0, 3));
        it.sample  = SAMPLE_W'($urandom_range(0, 1023));
        send_item(it);
    endtask

    task automatic send_sample(input logic [JOINT_W-1:0] ch, input logic [SAMPLE_W-1:0] v);
        cmd_item_t it;
        it.action  = ACT_SAMPLE;
        it.rx_char = CHAR_W'($urandom_range(0, 255));
        it.channel = ch;
        it.sample  = v;
        send_item(it);
    endtask

    task automatic send_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(CHAR_CR);
    endtask

    function automatic logic [CHAR_W-1:0] text_noise();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        if (c == CHAR_CR)
            c = c ^ 8'h01;
        return c;
    endfunction

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic load_limits(input limit_mode_t mode);
        logic [COUNTS_W-1:0] mn;
        logic [COUNTS_W-1:0] mx;
        int j;
        for (j = 0; j < NUM_JOINTS; j++)
        begin
            case (mode)
                LIM_DEFAULT:
                begin
                    mn = JMIN_RST[j];
                    mx = JMAX_RST[j];
                end
                LIM_WIDE:
                begin
                    mn = 8'd0;
                    mx = 8'd255;
                end
                LIM_ZERO:
                begin
                    mn = 8'd0;
                    mx = 8'd0;
                end
                LIM_FULL:
                begin
                    mn = 8'd255;
                    mx = 8'd255;
                end
                LIM_EQUAL:
                begin
                    mn = COUNTS_W'($urandom_range(0, 255));
                    mx = mn;
                end
                LIM_INVERTED:
                begin
                    mn = COUNTS_W'($urandom_range(128, 255));
                    mx = COUNTS_W'($urandom_range(0, 127));
                end
                default:
                begin
                    mn = COUNTS_W'($urandom_range(0, 255));
                    mx = COUNTS_W'($urandom_range(0, 255));
                end
            endcase
            write_reg({j[1:0], REG_SEL_MIN}, mn);
            write_reg({j[1:0], REG_SEL_MAX}, mx);
            lim_min[j] = mn;
            lim_max[j] = mx;
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_joint_cmd();
        int len;
        int i;
        if ($urandom_range(0, 9) == 0)
            send_char(text_noise());
        else
            send_char(CHAR_ZERO + 8'($urandom_range(0, 3)));
        // long text runs past the buffer depth and wraps
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_char(text_noise());
            else
                send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        send_char(CHAR_CR);
    endtask

    task automatic send_adc_burst();
        int n;
        int i;
        logic [SAMPLE_W-1:0] v;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = '1;
                default: v = SAMPLE_W'($urandom_range(0, 1023));
            endcase
            send_sample(JOINT_W'($urandom_range(0, 3)), v);
        end
    endtask

    task automatic send_noise_text();
        int len;
        int i;
        len = $urandom_range(1, 20);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_char(CHAR_CR);
            else
                send_char(text_noise());
        end
        send_char(CHAR_CR);
    endtask

    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            send_line("c");
        else if (pick < 30)
            send_line("r");
        else if (pick < 65)
            send_joint_cmd();
        else if (pick < 85)
            send_adc_burst();
        else
            send_noise_text();
    endtask

    task automatic run_random_phase(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_sequence();
    endtask

    task automatic test_directed();
        send_char(8'h00);
        send_char(CHAR_CR);
        send_char(CHAR_CR);                 // empty command
        send_sample(2'd0, 10'd0);
        send_sample(2'd3, 10'd1023);
        send_line("c");
        send_sample(2'd2, 10'h2AA);         // ignored while claimed
        send_line("1");                     // no degree digits
        send_char("2");
        send_char(8'hFF);                   // non-digits are skipped
        send_char("9");
        send_char("z");
        send_char("0");
        send_char(CHAR_CR);
        send_line("399999");                // degree saturation
        send_line("r");
        send_line("0");                     // joint digit while released
        send_line("cc");
        wait_for_results();
    endtask

    task automatic test_backpressure();
        int i;
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 8; i++)
            send_random_sequence();
        wait_for_results();
        idle_on = 1'b1;
    endtask

    task automatic test_limit_settings();
        limit_mode_t modes [7];
        int i;
        modes = '{LIM_RANDOM, LIM_WIDE, LIM_INVERTED, LIM_EQUAL, LIM_ZERO, LIM_FULL, LIM_RANDOM};
        run_random_phase(PHASE_ITEMS);
        for (i = 0; i < 7; i++)
        begin
            wait_for_results();
            load_limits(modes[i]);
            run_random_phase(PHASE_ITEMS);
        end
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        load_limits(LIM_DEFAULT);
        run_random_phase(PHASE_ITEMS);
        wait_for_results();
    endtask

    initial
    begin
        int j;
        for (j = 0; j < TEXT_DEPTH_DEF; j++)
            text_mem[j] = '0;
        for (j = 0; j < NUM_JOINTS; j++)
        begin
            lim_min[j] = JMIN_RST[j];
            lim_max[j] = JMAX_RST[j];
        end
        text_fill   = 0;
        remote_now  = 1'b0;
        items_sent  = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.action         <= ACT_CHAR;
        cmd_ch.rx_char        <= '0;
        cmd_ch.sample_channel <= '0;
        cmd_ch.sample_value   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_limit_settings();
        test_steady_stream();

        if (fail_count == 0 && pending_positions.size() == 0)
            $display("tb_servo_command_interpreter OK");
        else
            $display("tb_servo_command_interpreter NOT OK");
        $finish;
    end

endmodule
